[design/tcpr_pkg.sv]
// shared types, constants and helpers for the text cell pixel renderer
// no dependencies; used by the front, queue, back and top level

package tcpr_pkg;

  // default size of the font store
  localparam int GLYPH_SLOTS_DEFAULT     = 256;
  localparam int MAX_CELL_HEIGHT_DEFAULT = 32;

  // widest row the renderer draws; glyph rows are 16 bits
  localparam int MAX_CELL_WIDTH   = 16;
  localparam int CELL_WIDTH_LIMIT = (MAX_CELL_WIDTH < 16) ? MAX_CELL_WIDTH : 16;

  // queue between front and back
  localparam int QUEUE_DEPTH   = 4;
  localparam int QUEUE_PTR_W   = $clog2(QUEUE_DEPTH);
  localparam int QUEUE_COUNT_W = $clog2(QUEUE_DEPTH + 1);

  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 9;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_CELL_WIDTH   = 3'd0,
    REG_CELL_HEIGHT  = 3'd1,
    REG_FIRST_GLYPH  = 3'd2,
    REG_GLYPH_COUNT  = 3'd3,
    REG_DEFAULT_FORE = 3'd4,
    REG_DEFAULT_BACK = 3'd5
  } reg_index_t;

  typedef enum logic {
    CMD_LOAD   = 1'b0,
    CMD_RENDER = 1'b1
  } command_t;

  localparam logic [3:0] DEFAULT_INDEX = 4'd8;

  localparam logic [23:0] PAL_NORMAL [8] = '{
    24'h000000, 24'hFF0000, 24'h00FF00, 24'hFFFF00,
    24'h0000FF, 24'hFF00FF, 24'h00FFFF, 24'hFFFFFF
  };
  localparam logic [23:0] PAL_DIM [8] = '{
    24'h808080, 24'h800000, 24'h008000, 24'h808000,
    24'h000080, 24'h800080, 24'h008080, 24'hC0C0C0
  };

  // one rendered row waiting for the back end
  typedef struct packed {
    logic [23:0] fg;
    logic [23:0] bg;
    logic [15:0] lit;
    logic [4:0]  width;
  } row_job_t;

  function automatic logic [2:0] pick_index(input logic [3:0] idx, input logic [2:0] dflt);
    return (idx == DEFAULT_INDEX) ? dflt : idx[2:0];
  endfunction

endpackage

[design/text_cell_pixel_renderer.sv]
// top level of the text cell pixel renderer: front, queue and back
// depends on tcpr_pkg, tcpr_front, tcpr_queue, tcpr_back
//
//   channel   handshake               payload
//   -------   ---------------------   -------------------------------------------
//   in        in_valid / in_ready     command, glyph_code, cell_row, row_bits,
//                                     fore_index, back_index, five cell flags
//   out       out_valid / out_ready   pixel_rgb, column, last
//   cfg       cfg_write_en            cfg_index, cfg_data
//
// a render transaction yields one pixel per cycle while the output is not stalled,
// one per column of the effective cell width (1..16); a load yields nothing
// after acceptance a row goes through the s1 register, queue and output register
// a four-row queue lets loads and later renders enter while the back end draws
// reset clears control state and presets config; font store is garbage until loaded
// a stalled output holds the back end; the front stops once the queue is full

module text_cell_pixel_renderer #(
  parameter int GLYPH_SLOTS     = tcpr_pkg::GLYPH_SLOTS_DEFAULT,
  parameter int MAX_CELL_HEIGHT = tcpr_pkg::MAX_CELL_HEIGHT_DEFAULT
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_write_en,
  input  logic [tcpr_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [tcpr_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic                             command,
  input  logic [7:0]                       glyph_code,
  input  logic [4:0]                       cell_row,
  input  logic [15:0]                      row_bits,
  input  logic [3:0]                       fore_index,
  input  logic [3:0]                       back_index,
  input  logic                             inverse_flag,
  input  logic                             dim_flag,
  input  logic                             bold_flag,
  input  logic                             strike_flag,
  input  logic                             underline_flag,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [23:0]                      pixel_rgb,
  output logic [3:0]                       column,
  output logic                             last
);

  logic                               push;
  tcpr_pkg::row_job_t                 push_job;
  logic                               pop;
  logic                               head_valid;
  tcpr_pkg::row_job_t                 head_job;
  logic [tcpr_pkg::QUEUE_COUNT_W-1:0] queue_count;

  tcpr_front #(
    .GLYPH_SLOTS     (GLYPH_SLOTS),
    .MAX_CELL_HEIGHT (MAX_CELL_HEIGHT)
  ) u_front (
    .clk            (clk),
    .rst            (rst),
    .cfg_write_en   (cfg_write_en),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .command        (command),
    .glyph_code     (glyph_code),
    .cell_row       (cell_row),
    .row_bits       (row_bits),
    .fore_index     (fore_index),
    .back_index     (back_index),
    .inverse_flag   (inverse_flag),
    .dim_flag       (dim_flag),
    .bold_flag      (bold_flag),
    .strike_flag    (strike_flag),
    .underline_flag (underline_flag),
    .queue_count    (queue_count),
    .push           (push),
    .push_job       (push_job)
  );

  tcpr_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_job   (push_job),
    .pop        (pop),
    .head_valid (head_valid),
    .head_job   (head_job),
    .count      (queue_count)
  );

  tcpr_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head_job   (head_job),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .pixel_rgb  (pixel_rgb),
    .column     (column),
    .last       (last)
  );

endmodule

[design/tcpr_front.sv]
// front end: configuration registers, font store, command decode and row preparation
// depends on tcpr_pkg

module tcpr_front #(
  parameter int GLYPH_SLOTS     = tcpr_pkg::GLYPH_SLOTS_DEFAULT,
  parameter int MAX_CELL_HEIGHT = tcpr_pkg::MAX_CELL_HEIGHT_DEFAULT
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_write_en,
  input  logic [tcpr_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [tcpr_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic                               command,
  input  logic [7:0]                         glyph_code,
  input  logic [4:0]                         cell_row,
  input  logic [15:0]                        row_bits,
  input  logic [3:0]                         fore_index,
  input  logic [3:0]                         back_index,
  input  logic                               inverse_flag,
  input  logic                               dim_flag,
  input  logic                               bold_flag,
  input  logic                               strike_flag,
  input  logic                               underline_flag,
  input  logic [tcpr_pkg::QUEUE_COUNT_W-1:0] queue_count,
  output logic                               push,
  output tcpr_pkg::row_job_t                 push_job
);

  localparam int STORE_DEPTH = GLYPH_SLOTS * MAX_CELL_HEIGHT;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);
  localparam int QW          = tcpr_pkg::QUEUE_COUNT_W;
  localparam logic [4:0] WMAX   = 5'(tcpr_pkg::CELL_WIDTH_LIMIT);
  localparam logic [5:0] HMAX   = 6'((MAX_CELL_HEIGHT < 32) ? MAX_CELL_HEIGHT : 32);
  localparam logic [6:0] ROWS_V = 7'(MAX_CELL_HEIGHT);
  localparam logic [8:0] SLOTS_V = 9'(GLYPH_SLOTS);

  logic [4:0] cell_width;
  logic [5:0] cell_height;
  logic [7:0] first_glyph;
  logic [8:0] glyph_count;
  logic [2:0] default_fore;
  logic [2:0] default_back;

  logic [15:0] font_store [STORE_DEPTH];
  logic [15:0] rdata;

  logic        s1_valid;
  logic [23:0] s1_fg;
  logic [23:0] s1_bg;
  logic        s1_use_glyph;
  logic        s1_bold;
  logic        s1_full;
  logic [15:0] s1_mask;
  logic [4:0]  s1_width;

  logic              accept;
  logic              is_render;
  logic [QW:0]       pending;
  logic [ADDR_W-1:0] addr;
  logic              load_ok;
  logic [3:0]        fi;
  logic [3:0]        bi;
  logic [23:0]       fg;
  logic [23:0]       bg;
  logic [4:0]        w_eff;
  logic [5:0]        h_eff;
  logic [5:0]        row6;
  logic [8:0]        code9;
  logic              glyph_ok;
  logic              row_in;
  logic              full;
  logic [15:0]       mask;
  logic [15:0]       glyph;

  // s1 always drains into the queue, so count it as taken
  assign pending   = {1'b0, queue_count} + {{QW{1'b0}}, s1_valid};
  assign in_ready  = pending < (QW + 1)'(tcpr_pkg::QUEUE_DEPTH);
  assign accept    = in_valid && in_ready;
  assign is_render = (tcpr_pkg::command_t'(command) == tcpr_pkg::CMD_RENDER);

  assign addr = ADDR_W'(glyph_code) * ADDR_W'(MAX_CELL_HEIGHT) + ADDR_W'(cell_row);
  assign code9 = {1'b0, glyph_code};
  assign row6  = {1'b0, cell_row};
  assign load_ok = (code9 < SLOTS_V) && ({2'b00, cell_row} < ROWS_V);

  always_comb begin
    fi = inverse_flag ? back_index : fore_index;
    bi = inverse_flag ? fore_index : back_index;
    fg = dim_flag ? tcpr_pkg::PAL_DIM[tcpr_pkg::pick_index(fi, default_fore)]
                  : tcpr_pkg::PAL_NORMAL[tcpr_pkg::pick_index(fi, default_fore)];
    bg = tcpr_pkg::PAL_NORMAL[tcpr_pkg::pick_index(bi, default_back)];

    if (cell_width == 5'd0) begin
      w_eff = 5'd1;
    end else if (cell_width > WMAX) begin
      w_eff = WMAX;
    end else begin
      w_eff = cell_width;
    end
    if (cell_height == 6'd0) begin
      h_eff = 6'd1;
    end else if (cell_height > HMAX) begin
      h_eff = HMAX;
    end else begin
      h_eff = cell_height;
    end

    glyph_ok = (glyph_code >= first_glyph) &&
               ((code9 - {1'b0, first_glyph}) < glyph_count) && (code9 < SLOTS_V);
    row_in = row6 < h_eff;
    full = (strike_flag && row6 == ((h_eff - 6'd1) >> 1)) ||
           (underline_flag && row6 == (h_eff - 6'd1));
    mask = ~(16'hFFFF << w_eff);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cell_width   <= 5'd8;
      cell_height  <= 6'd16;
      first_glyph  <= 8'd32;
      glyph_count  <= 9'd96;
      default_fore <= 3'd7;
      default_back <= 3'd0;
    end else if (cfg_write_en) begin
      unique case (tcpr_pkg::reg_index_t'(cfg_index))
        tcpr_pkg::REG_CELL_WIDTH:   cell_width   <= cfg_data[4:0];
        tcpr_pkg::REG_CELL_HEIGHT:  cell_height  <= cfg_data[5:0];
        tcpr_pkg::REG_FIRST_GLYPH:  first_glyph  <= cfg_data[7:0];
        tcpr_pkg::REG_GLYPH_COUNT:  glyph_count  <= cfg_data[8:0];
        tcpr_pkg::REG_DEFAULT_FORE: default_fore <= cfg_data[2:0];
        tcpr_pkg::REG_DEFAULT_BACK: default_back <= cfg_data[2:0];
        default: ;
      endcase
    end
  end

  // font store: one write or one read per transaction, read data registered
  always_ff @(posedge clk) begin
    if (accept && !is_render && load_ok) begin
      font_store[addr] <= row_bits;
    end
    if (accept && is_render) begin
      rdata <= font_store[addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= accept && is_render;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && is_render) begin
      s1_fg        <= fg;
      s1_bg        <= bg;
      s1_use_glyph <= glyph_ok && row_in;
      s1_bold      <= bold_flag;
      s1_full      <= full;
      s1_mask      <= mask;
      s1_width     <= w_eff;
    end
  end

  // bold smears each lit pixel one column right
  assign glyph = rdata | (s1_bold ? {rdata[14:0], 1'b0} : 16'h0000);

  assign push           = s1_valid;
  assign push_job.fg    = s1_fg;
  assign push_job.bg    = s1_bg;
  assign push_job.lit   = s1_full ? s1_mask : ((s1_use_glyph ? glyph : 16'h0000) & s1_mask);
  assign push_job.width = s1_width;

endmodule

[design/tcpr_queue.sv]
// small fifo of prepared rows between front and back
// depends on tcpr_pkg

module tcpr_queue (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               push,
  input  tcpr_pkg::row_job_t                 push_job,
  input  logic                               pop,
  output logic                               head_valid,
  output tcpr_pkg::row_job_t                 head_job,
  output logic [tcpr_pkg::QUEUE_COUNT_W-1:0] count
);

  localparam int PW = tcpr_pkg::QUEUE_PTR_W;
  localparam int CW = tcpr_pkg::QUEUE_COUNT_W;

  tcpr_pkg::row_job_t entries [tcpr_pkg::QUEUE_DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(tcpr_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(tcpr_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      count <= count + CW'(push) - CW'(pop);
    end
  end

  assign head_valid = (count != '0);
  assign head_job   = entries[rd_ptr];

endmodule

[design/tcpr_back.sv]
// back end: walks a prepared row one pixel per cycle, while the output is not stalled, into the output register
// depends on tcpr_pkg

module tcpr_back (
  input  logic               clk,
  input  logic               rst,
  input  logic               head_valid,
  input  tcpr_pkg::row_job_t head_job,
  output logic               pop,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [23:0]        pixel_rgb,
  output logic [3:0]         column,
  output logic               last
);

  logic [3:0] x;
  logic       advance;
  logic       at_end;

  assign advance = !out_valid || out_ready;
  assign at_end  = ({1'b0, x} + 5'd1) == head_job.width;
  assign pop     = advance && head_valid && at_end;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      x         <= 4'd0;
    end else if (advance) begin
      out_valid <= head_valid;
      if (head_valid) begin
        x <= at_end ? 4'd0 : x + 4'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance && head_valid) begin
      pixel_rgb <= head_job.lit[x] ? head_job.fg : head_job.bg;
      column    <= x;
      last      <= at_end;
    end
  end

endmodule

[design/tcpr_checker.sv]
// port-level checks on the renderer output stream, bound to the top level
// depends only on the top-level ports

module tcpr_checker (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_ready,
  input logic [23:0] pixel_rgb,
  input logic [3:0]  column,
  input logic        last
);

  // stalled output holds its pixel
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(pixel_rgb) && $stable(column) &&
    $stable(last))
    else $error("output changed while stalled");

  // a row continues with the next column until its last pixel
  a_next_col: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && !last |=> !out_valid || column == $past(column) + 4'd1)
    else $error("column did not advance within a row");

  // a row that follows a last pixel starts at column zero
  a_row_start: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && last |=> !out_valid || column == 4'd0)
    else $error("row did not start at column zero");

  // the widest row ends at column fifteen
  a_max_col: assert property (@(posedge clk) disable iff (rst)
    out_valid && column == 4'd15 |-> last)
    else $error("column fifteen not marked last");

endmodule

bind text_cell_pixel_renderer tcpr_checker u_tcpr_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .pixel_rgb (pixel_rgb),
  .column    (column),
  .last      (last)
);

[bench/tb_text_cell_pixel_renderer.sv]
// self-checking bench for text_cell_pixel_renderer: loads glyph rows, renders cell rows
// and compares every pixel with a local prediction; depends on tcpr_pkg and the rtl

module tb_text_cell_pixel_renderer;

  localparam int FONT_CODES     = tcpr_pkg::GLYPH_SLOTS_DEFAULT;
  localparam int FONT_ROWS      = tcpr_pkg::MAX_CELL_HEIGHT_DEFAULT;
  localparam int HEIGHT_LIMIT   = (FONT_ROWS < 32) ? FONT_ROWS : 32;
  localparam int LONG_HOLD      = 300;
  localparam int SETTLE_CYCLES  = 10;
  localparam int WATCHDOG_LIMIT = 4000;

  typedef struct {
    tcpr_pkg::command_t cmd;
    logic [7:0]  code;
    logic [4:0]  row;
    logic [15:0] row_bits;
    logic [3:0]  fore;
    logic [3:0]  back;
    logic        inverse;
    logic        dim;
    logic        bold;
    logic        strike;
    logic        underline;
  } cell_item_t;

  typedef struct {
    logic [23:0] rgb;
    logic [3:0]  col;
    logic        last;
  } pixel_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_write_en = 1'b0;
  logic [tcpr_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
  logic [tcpr_pkg::CFG_DATA_W-1:0]  cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        command = 1'b0;
  logic [7:0]  glyph_code = '0;
  logic [4:0]  cell_row = '0;
  logic [15:0] row_bits = '0;
  logic [3:0]  fore_index = '0;
  logic [3:0]  back_index = '0;
  logic        inverse_flag = 1'b0;
  logic        dim_flag = 1'b0;
  logic        bold_flag = 1'b0;
  logic        strike_flag = 1'b0;
  logic        underline_flag = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [23:0] pixel_rgb;
  logic [3:0]  column;
  logic        last;

  // register copies shared by stimulus and prediction; only changed while idle
  logic [4:0] width_reg = 5'd8;
  logic [5:0] height_reg = 6'd16;
  logic [7:0] first_reg = 8'd32;
  logic [8:0] count_reg = 9'd96;
  logic [2:0] fore_reg = 3'd7;
  logic [2:0] back_reg = 3'd0;

  logic [15:0] font_copy [FONT_CODES*FONT_ROWS];
  bit          row_written [FONT_CODES*FONT_ROWS];

  cell_item_t pending_cells [$];
  pixel_t     expected_pixels [$];
  cell_item_t offer;
  int         mismatch_count = 0;
  int         send_idle_pct = 0;
  int         recv_stall_pct = 0;
  bit         hold_toggle = 1'b0;
  bit         hold_seen = 1'b0;
  int         hold_left = 0;
  int         quiet_cycles = 0;

  text_cell_pixel_renderer u_top (
    .clk            (clk),
    .rst            (rst),
    .cfg_write_en   (cfg_write_en),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .command        (command),
    .glyph_code     (glyph_code),
    .cell_row       (cell_row),
    .row_bits       (row_bits),
    .fore_index     (fore_index),
    .back_index     (back_index),
    .inverse_flag   (inverse_flag),
    .dim_flag       (dim_flag),
    .bold_flag      (bold_flag),
    .strike_flag    (strike_flag),
    .underline_flag (underline_flag),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .pixel_rgb      (pixel_rgb),
    .column         (column),
    .last           (last)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int eff_width();
    int w;
    w = width_reg;
    if (w < 1) w = 1;
    if (w > tcpr_pkg::CELL_WIDTH_LIMIT) w = tcpr_pkg::CELL_WIDTH_LIMIT;
    return w;
  endfunction

  function automatic int eff_height();
    int h;
    h = height_reg;
    if (h < 1) h = 1;
    if (h > HEIGHT_LIMIT) h = HEIGHT_LIMIT;
    return h;
  endfunction

  function automatic bit glyph_valid(input int code);
    return code >= first_reg && (code - first_reg) < count_reg && code < FONT_CODES;
  endfunction

  // load updates the font copy; render pushes one expected pixel per column
  task automatic apply_cell_item(input cell_item_t it);
    int w, h, lit, mask, r;
    logic [3:0] fi, bi;
    logic [23:0] fg, bg;
    pixel_t px;
    if (it.cmd == tcpr_pkg::CMD_LOAD) begin
      font_copy[it.code*FONT_ROWS + it.row] = it.row_bits;
    end else begin
      w = eff_width();
      h = eff_height();
      r = it.row;
      fi = it.inverse ? it.back : it.fore;
      bi = it.inverse ? it.fore : it.back;
      fg = (fi == tcpr_pkg::DEFAULT_INDEX)
             ? (it.dim ? tcpr_pkg::PAL_DIM[fore_reg] : tcpr_pkg::PAL_NORMAL[fore_reg])
             : (it.dim ? tcpr_pkg::PAL_DIM[fi[2:0]] : tcpr_pkg::PAL_NORMAL[fi[2:0]]);
      bg = (bi == tcpr_pkg::DEFAULT_INDEX) ? tcpr_pkg::PAL_NORMAL[back_reg]
                                           : tcpr_pkg::PAL_NORMAL[bi[2:0]];
      mask = (1 << w) - 1;
      lit = 0;
      if (glyph_valid(it.code) && r < h) begin
        lit = font_copy[it.code*FONT_ROWS + r];
        if (it.bold) lit = lit | (lit << 1);
      end
      lit = lit & mask;
      if ((it.strike && r == (h - 1) / 2) || (it.underline && r == h - 1)) lit = mask;
      for (int x = 0; x < w; x++) begin
        px.rgb  = lit[x] ? fg : bg;
        px.col  = x[3:0];
        px.last = (x + 1 == w);
        expected_pixels.push_back(px);
      end
    end
  endtask

  task automatic queue_load(input int code, input int r, input logic [15:0] pattern);
    cell_item_t it;
    it = '{tcpr_pkg::CMD_LOAD, code[7:0], r[4:0], pattern, 4'd0, 4'd0,
           1'b0, 1'b0, 1'b0, 1'b0, 1'b0};
    row_written[code*FONT_ROWS + r] = 1'b1;
    pending_cells.push_back(it);
  endtask

  // flags: {inverse, dim, bold, strike, underline}; loads a valid, unwritten row first
  task automatic queue_render(input int code, input int r, input int fi, input int bi,
                              input logic [4:0] flags);
    cell_item_t it;
    if (glyph_valid(code) && r < eff_height() && !row_written[code*FONT_ROWS + r])
      queue_load(code, r, 16'($urandom()));
    it = '{tcpr_pkg::CMD_RENDER, code[7:0], r[4:0], 16'($urandom()), fi[3:0], bi[3:0],
           flags[4], flags[3], flags[2], flags[1], flags[0]};
    pending_cells.push_back(it);
  endtask

  task automatic queue_random_cell();
    int code, r, span, h, pick;
    h = eff_height();
    if ($urandom_range(99) < 15) begin
      queue_load($urandom_range(255), $urandom_range(31), 16'($urandom()));
    end else begin
      span = count_reg;
      if (first_reg + span > FONT_CODES) span = FONT_CODES - first_reg;
      if (span > 0 && $urandom_range(99) < 75) code = first_reg + $urandom_range(span - 1);
      else code = $urandom_range(255);
      pick = $urandom_range(99);
      if (pick < 10) r = (h - 1) / 2;
      else if (pick < 20) r = h - 1;
      else if (pick < 80) r = $urandom_range(h - 1);
      else r = $urandom_range(31);
      queue_render(code, r, $urandom_range(8), $urandom_range(8), 5'($urandom()));
    end
  endtask

  task automatic write_reg(input tcpr_pkg::reg_index_t idx, input int value);
    cfg_write_en <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value[tcpr_pkg::CFG_DATA_W-1:0];
    @(posedge clk);
  endtask

  task automatic set_config(input int w, input int h, input int first, input int count,
                            input int fore, input int back);
    write_reg(tcpr_pkg::REG_CELL_WIDTH, w);
    write_reg(tcpr_pkg::REG_CELL_HEIGHT, h);
    write_reg(tcpr_pkg::REG_FIRST_GLYPH, first);
    write_reg(tcpr_pkg::REG_GLYPH_COUNT, count);
    write_reg(tcpr_pkg::REG_DEFAULT_FORE, fore);
    write_reg(tcpr_pkg::REG_DEFAULT_BACK, back);
    cfg_write_en <= 1'b0;
    width_reg = w[4:0];
    height_reg = h[5:0];
    first_reg = first[7:0];
    count_reg = count[8:0];
    fore_reg = fore[2:0];
    back_reg = back[2:0];
  endtask

  // loads leave nothing to wait for, so settle after the last expected pixel is seen
  // the falling edge sees the sender's and receiver's updates of the rising edge
  task automatic wait_for_drain();
    while (pending_cells.size() > 0 || in_valid || expected_pixels.size() > 0)
      @(negedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic run_phase(input int n_items, input int idle_pct, input int stall_pct);
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    for (int i = 0; i < n_items; i++) queue_random_cell();
  endtask

  // sender: one transaction at a time from pending_cells
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) apply_cell_item(offer);
      if (!in_valid || in_ready) begin
        if (pending_cells.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          offer = pending_cells.pop_front();
          in_valid <= 1'b1;
          command <= offer.cmd;
          glyph_code <= offer.code;
          cell_row <= offer.row;
          row_bits <= offer.row_bits;
          fore_index <= offer.fore;
          back_index <= offer.back;
          inverse_flag <= offer.inverse;
          dim_flag <= offer.dim;
          bold_flag <= offer.bold;
          strike_flag <= offer.strike;
          underline_flag <= offer.underline;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // receiver: checks each pixel transaction and drives out_ready
  always @(posedge clk) begin
    pixel_t exp_px;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_pixels.size() == 0) begin
          $error("unexpected pixel: pixel_rgb %h column %0d last %0b", pixel_rgb, column, last);
          mismatch_count++;
        end else begin
          exp_px = expected_pixels.pop_front();
          if (pixel_rgb !== exp_px.rgb) begin
            $error("pixel_rgb expected %h actual %h", exp_px.rgb, pixel_rgb);
            mismatch_count++;
          end
          if (column !== exp_px.col) begin
            $error("column expected %0d actual %0d", exp_px.col, column);
            mismatch_count++;
          end
          if (last !== exp_px.last) begin
            $error("last expected %0b actual %0b", exp_px.last, last);
            mismatch_count++;
          end
        end
      end
      if (hold_toggle != hold_seen) begin
        hold_seen <= hold_toggle;
        hold_left <= LONG_HOLD;
        out_ready <= 1'b0;
      end else if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // watchdog: only counts while work is outstanding
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (pending_cells.size() > 0 || in_valid || expected_pixels.size() > 0) begin
      if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
        $display("Mismatches found");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed cases at reset settings: width 8, height 16, glyphs 32..127
    queue_load(65, 0, 16'hFFFF);
    queue_load(65, 1, 16'h0081);
    queue_load(65, 2, 16'h8000);
    queue_render(65, 0, 8, 8, 5'b00000);
    queue_render(65, 1, 2, 5, 5'b00100);
    queue_render(65, 1, 3, 8, 5'b11000);
    queue_render(65, 0, 8, 1, 5'b11000);
    queue_render(65, 2, 4, 6, 5'b00100);
    queue_render(65, 7, 1, 2, 5'b00010);
    queue_render(65, 15, 6, 4, 5'b01001);
    queue_render(10, 7, 5, 3, 5'b00010);
    queue_render(255, 15, 0, 7, 5'b10001);
    queue_render(10, 3, 7, 0, 5'b00000);
    queue_render(65, 20, 7, 1, 5'b00111);
    queue_render(127, 31, 8, 8, 5'b00011);
    queue_render(32, 4, 8, 8, 5'b11111);
    queue_render(0, 0, 8, 8, 5'b00000);
    send_idle_pct = 0;
    recv_stall_pct = 0;
    wait_for_drain();

    set_config(16, 32, 0, 256, 0, 7);
    run_phase(70, 0, 0);
    wait_for_drain();

    set_config(1, 1, 255, 1, 7, 0);
    run_phase(70, 80, 0);
    wait_for_drain();

    set_config(5, 7, 200, 0, 2, 6);
    run_phase(70, 0, 80);
    wait_for_drain();

    // out-of-range width and height, count past the last code
    set_config(31, 0, 100, 300, 3, 5);
    run_phase(70, 9, 9);
    wait_for_drain();

    set_config(12, 63, 10, 20, 1, 4);
    run_phase(70, 0, 0);
    hold_toggle <= ~hold_toggle;
    wait_for_drain();

    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
